// ----- sv/dam_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dam_pkg
// Shared types, codes and helpers for the daily alarm matcher.
// ----------------------------------------------------------------------------
package dam_pkg;

  typedef enum logic [1:0] {
    CMD_CHECK  = 2'd0,
    CMD_SET    = 2'd1,
    CMD_SET_EN = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // One alarm slot as held in the slot store.
  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        enable;
    logic        fired;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } slot_t;

  // Calendar time presented to the compare unit.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [5:0]  second;
  } now_t;

  localparam logic [4:0] ResetHour   = 5'd8;
  localparam logic [5:0] ResetMinute = 6'd30;

  localparam slot_t SlotReset = '{
    hour:   ResetHour,
    minute: ResetMinute,
    enable: 1'b0,
    fired:  1'b0,
    year:   14'd0,
    month:  4'd0,
    day:    5'd0
  };

  // v mod 24 for an 8-bit value: quotient by reciprocal 171/4096, exact here.
  function automatic logic [4:0] mod24(logic [7:0] v);
    logic [15:0] p;
    logic [3:0]  q;
    logic [7:0]  r;
    p = 16'(v) * 16'd171;
    q = p[15:12];
    r = v - ({4'd0, q} * 8'd24);
    return r[4:0];
  endfunction

  // v mod 60 for an 8-bit value: quotient by reciprocal 137/8192, exact here.
  function automatic logic [5:0] mod60(logic [7:0] v);
    logic [15:0] p;
    logic [2:0]  q;
    logic [7:0]  r;
    p = 16'(v) * 16'd137;
    q = p[15:13];
    r = v - ({5'd0, q} * 8'd60);
    return r[5:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/daily_alarm_matcher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// daily_alarm_matcher
// Table of daily alarms with check, set, set-enable and read commands.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Ports
//   -------   ----------------   ---------------------------------------------
//   command   start / busy       command_i year_i month_i day_i hour_i
//                                minute_i second_i alarm_slot_i enable_i
//   result    valid_o (strobe)   ok_o fired_o fired_slot_o read_hour_o
//                                read_minute_o read_enable_o
//
// A command word is taken at a clock edge with start high and busy low. A
// check then visits the slots from slot 0 upward, stopping
// at the first slot that fires or at the last slot; set, set-enable and read
// work on the addressed slot alone. The single compare unit sees one slot of
// the store per cycle.
// The result word appears on the strobe in the cycle in which busy falls and
// cannot be stalled; a new command may be taken while it is shown.
// Reset returns every slot to 8:30, disabled, with no fired flag.
// ----------------------------------------------------------------------------
module daily_alarm_matcher
  import dam_pkg::*;
#(
  parameter int ALARM_SLOTS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command_i,
  input  wire logic [13:0] year_i,
  input  wire logic [3:0]  month_i,
  input  wire logic [4:0]  day_i,
  input  wire logic [7:0]  hour_i,
  input  wire logic [7:0]  minute_i,
  input  wire logic [5:0]  second_i,
  input  wire logic [7:0]  alarm_slot_i,
  input  wire logic        enable_i,
  output logic             valid_o,
  output logic             ok_o,
  output logic             fired_o,
  output logic [1:0]       fired_slot_o,
  output logic [4:0]       read_hour_o,
  output logic [5:0]       read_minute_o,
  output logic             read_enable_o
);

  // A single slot still needs a one-bit index.
  localparam int IdxW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ALARM_SLOTS - 1);

  state_e state_q, state_d;

  // Captured command word. These are payload registers and need no reset.
  cmd_e   cmd_q;
  now_t   now_q;
  logic   en_q;
  logic   bad_slot_q;

  logic [IdxW-1:0] idx_q, idx_d;

  // Slot store port and compare unit.
  logic  wr_en;
  slot_t wr_data;
  slot_t rd_data;
  logic  hit;
  slot_t chk_next;
  logic  done;

  // Result word.
  logic       valid_q;
  logic       ok_q, fired_q, read_en_q;
  logic [1:0] fired_slot_q;
  logic [4:0] read_hour_q;
  logic [5:0] read_minute_q;
  logic       ok_d, fired_d, read_en_d;
  logic [1:0] fired_slot_d;
  logic [4:0] read_hour_d;
  logic [5:0] read_minute_d;

  logic accept;
  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  dam_slot_store #(
    .Slots(ALARM_SLOTS),
    .IdxW (IdxW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .idx_i    (idx_q),
    .wr_en_i  (wr_en),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  dam_match_unit u_match (
    .now_i (now_q),
    .slot_i(rd_data),
    .hit_o (hit),
    .next_o(chk_next)
  );

  // Capture the command word on acceptance. The sequencer loads the slot index
  // register with the addressed slot, or with slot 0 to start a scan or when the slot is out of range.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_e'(command_i);
      now_q      <= '{year: year_i, month: month_i, day: day_i,
                      hour: hour_i, minute: minute_i, second: second_i};
      en_q       <= enable_i;
      bad_slot_q <= ({24'd0, alarm_slot_i} >= 32'(ALARM_SLOTS));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Sequencer: one slot per cycle during a check, the addressed slot otherwise.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    wr_en   = 1'b0;
    wr_data = rd_data;
    done    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
          if (cmd_e'(command_i) == CMD_CHECK ||
              {24'd0, alarm_slot_i} >= 32'(ALARM_SLOTS)) begin
            idx_d = '0;
          end else begin
            idx_d = IdxW'(alarm_slot_i);
          end
        end
      end
      ST_EXEC: begin
        unique case (cmd_q)
          CMD_CHECK: begin
            wr_en   = 1'b1;
            wr_data = chk_next;
            if (hit || idx_q == LastIdx) begin
              done = 1'b1;
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
          CMD_SET: begin
            done           = 1'b1;
            wr_en          = !bad_slot_q;
            wr_data.hour   = mod24(now_q.hour);
            wr_data.minute = mod60(now_q.minute);
            wr_data.enable = en_q;
            wr_data.fired  = 1'b0;
          end
          CMD_SET_EN: begin
            done           = 1'b1;
            wr_en          = !bad_slot_q;
            wr_data.enable = en_q;
            wr_data.fired  = 1'b0;
          end
          CMD_READ: begin
            done = 1'b1;
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The strobe is a one-cycle pulse, registered from done in the last working cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= done;
    end
  end

  // Result fields; anything a command does not produce reads as zero.
  always_comb begin
    ok_d          = 1'b0;
    fired_d       = 1'b0;
    fired_slot_d  = 2'd0;
    read_hour_d   = 5'd0;
    read_minute_d = 6'd0;
    read_en_d     = 1'b0;
    if (cmd_q == CMD_CHECK) begin
      if (hit) begin
        ok_d         = 1'b1;
        fired_d      = 1'b1;
        fired_slot_d = 2'(idx_q);
      end
    end else if (!bad_slot_q) begin
      ok_d = 1'b1;
      if (cmd_q == CMD_READ) begin
        read_hour_d   = rd_data.hour;
        read_minute_d = rd_data.minute;
        read_en_d     = rd_data.enable;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      ok_q          <= ok_d;
      fired_q       <= fired_d;
      fired_slot_q  <= fired_slot_d;
      read_hour_q   <= read_hour_d;
      read_minute_q <= read_minute_d;
      read_en_q     <= read_en_d;
    end
  end

  assign valid_o       = valid_q;
  assign ok_o          = ok_q;
  assign fired_o       = fired_q;
  assign fired_slot_o  = fired_slot_q;
  assign read_hour_o   = read_hour_q;
  assign read_minute_o = read_minute_q;
  assign read_enable_o = read_en_q;

endmodule
`default_nettype wire

// ----- sv/dam_slot_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dam_slot_store
// Register file of alarm slots with one shared read and write address.
// ----------------------------------------------------------------------------
module dam_slot_store
  import dam_pkg::*;
#(
  parameter int Slots = 4,
  parameter int IdxW  = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [IdxW-1:0] idx_i,
  input  wire logic            wr_en_i,
  input  wire slot_t           wr_data_i,
  output slot_t                rd_data_o
);

  slot_t slots_q [Slots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Slots; k++) begin
        slots_q[k] <= SlotReset;
      end
    end else if (wr_en_i) begin
      slots_q[idx_i] <= wr_data_i;
    end
  end

  assign rd_data_o = slots_q[idx_i];

endmodule
`default_nettype wire

// ----- sv/dam_match_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dam_match_unit
// Compare unit shared by all slots: date roll-over and alarm match for one
// slot, with the slot's updated contents after a check.
// ----------------------------------------------------------------------------
module dam_match_unit
  import dam_pkg::*;
(
  input  wire now_t  now_i,
  input  wire slot_t slot_i,
  output logic       hit_o,
  output slot_t      next_o
);

  logic stale;
  logic fired_eff;

  always_comb begin
    stale     = (slot_i.year != now_i.year) || (slot_i.month != now_i.month) ||
                (slot_i.day != now_i.day);
    fired_eff = slot_i.fired && !stale;
    hit_o     = slot_i.enable && !fired_eff &&
                ({3'd0, slot_i.hour} == now_i.hour) &&
                ({2'd0, slot_i.minute} == now_i.minute) &&
                (now_i.second == 6'd0);
    next_o       = slot_i;
    next_o.fired = fired_eff || hit_o;
    if (hit_o) begin
      next_o.year  = now_i.year;
      next_o.month = now_i.month;
      next_o.day   = now_i.day;
    end
  end

endmodule
`default_nettype wire

// ----- sv/dam_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dam_checker
// Port-level checks on the command and result handshakes.
// ----------------------------------------------------------------------------
module dam_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       valid_o,
  input wire logic       ok_o,
  input wire logic       fired_o,
  input wire logic [4:0] read_hour_o
);

  // An accepted command word always makes the block busy.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // The result word appears exactly when the block finishes.
  a_done_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o)
    else $error("busy fell without a result strobe");

  a_strobe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (!busy && !$past(valid_o)))
    else $error("result strobe while busy or for two cycles");

  a_fired_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && fired_o) |-> (ok_o && read_hour_o == 5'd0))
    else $error("fired result with bad ok or read field");

endmodule

bind daily_alarm_matcher dam_checker u_dam_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .valid_o    (valid_o),
  .ok_o       (ok_o),
  .fired_o    (fired_o),
  .read_hour_o(read_hour_o)
);
`default_nettype wire
